// ----- rtl/okl_pkg.sv -----
package okl_pkg;

  localparam int unsigned ListDepthDefault = 16;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ModeW = 2;
  localparam int unsigned StatusW = 2;

  localparam logic [ModeW-1:0] ModeAppend = 2'd0;
  localparam logic [ModeW-1:0] ModeRemove = 2'd1;

  localparam logic [StatusW-1:0] StatusOk = 2'd0;
  localparam logic [StatusW-1:0] StatusFull = 2'd1;
  localparam logic [StatusW-1:0] StatusNotFound = 2'd2;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd3;

  typedef struct packed {
    logic append;
    logic remove;
    logic rotate;
  } cell_ctrl_t;

endpackage

// ----- rtl/ordered_key_list_unit.sv -----
// append and remove: result word registered at accept; one item per cycle when not stalled
// dump: accept enters ST_DUMP, which registers one entry word per cycle while output is free
// input is held off while a dump is streaming; an empty dump yields one word
// all cells compare against the key in parallel; a dump rotates the cell chain once around
// reset (rst_ni low, asynchronous) empties the list and drops any pending output word
module ordered_key_list_unit #(
  parameter int unsigned LIST_DEPTH = okl_pkg::ListDepthDefault,
  localparam int unsigned CountW = $clog2(LIST_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [okl_pkg::ModeW-1:0]           mode_i,
  input  logic signed [okl_pkg::KeyW-1:0]     key_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [okl_pkg::KeyW-1:0]     entry_key_o,
  output logic [okl_pkg::StatusW-1:0]         status_o,
  output logic [CountW-1:0]                   entry_count_o,
  output logic                                last_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  localparam logic [CountW-1:0] Depth = CountW'(LIST_DEPTH);

  state_e state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic signed [okl_pkg::KeyW-1:0] out_key_q, out_key_d;
  logic [okl_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic out_last_q, out_last_d;

  okl_pkg::cell_ctrl_t ctrl;
  logic out_free, in_accept, dump_last;

  logic signed [okl_pkg::KeyW-1:0] ent [LIST_DEPTH+1];
  logic [LIST_DEPTH:0] vld_ext;
  logic [LIST_DEPTH:0] pv_ext;
  logic [LIST_DEPTH:0] hit;
  logic [LIST_DEPTH-1:0] vld;

  assign ent[LIST_DEPTH] = '0;
  assign vld_ext = {1'b0, vld};
  assign pv_ext  = {vld, 1'b1};
  assign hit[0]  = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    okl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key_i),
      .head_key_i   (ent[0]),
      .prev_valid_i (pv_ext[i]),
      .nbr_entry_i  (ent[i+1]),
      .nbr_valid_i  (vld_ext[i+1]),
      .hit_i        (hit[i]),
      .hit_o        (hit[i+1]),
      .entry_o      (ent[i]),
      .valid_o      (vld[i])
    );
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;
  assign dump_last  = ((idx_q + CountW'(1)) == count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_key_d    = out_key_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    ctrl         = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          out_key_d  = '0;
          out_last_d = 1'b1;
          if (mode_i[1]) begin
            if (count_q == '0) begin
              out_valid_d  = 1'b1;
              out_status_d = okl_pkg::StatusEmpty;
              out_count_d  = '0;
            end else begin
              state_d = ST_DUMP;
              idx_d   = '0;
            end
          end else if (mode_i == okl_pkg::ModeAppend) begin
            out_valid_d = 1'b1;
            if (count_q == Depth) begin
              out_status_d = okl_pkg::StatusFull;
              out_count_d  = count_q;
            end else begin
              ctrl.append  = 1'b1;
              count_d      = count_q + CountW'(1);
              out_status_d = okl_pkg::StatusOk;
              out_count_d  = count_q + CountW'(1);
            end
          end else begin
            out_valid_d = 1'b1;
            if (hit[LIST_DEPTH]) begin
              ctrl.remove  = 1'b1;
              count_d      = count_q - CountW'(1);
              out_status_d = okl_pkg::StatusOk;
              out_count_d  = count_q - CountW'(1);
            end else begin
              out_status_d = okl_pkg::StatusNotFound;
              out_count_d  = count_q;
            end
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          ctrl.rotate  = 1'b1;
          out_valid_d  = 1'b1;
          out_key_d    = ent[0];
          out_status_d = okl_pkg::StatusOk;
          out_count_d  = count_q;
          out_last_d   = dump_last;
          idx_d        = idx_q + CountW'(1);
          if (dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_key_q    <= out_key_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign entry_key_o   = out_key_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;
  assign last_o        = out_last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Depth)
    else $error("entry count above depth");

  a_valid_matches_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld) == int'(count_q))
    else $error("cell valid bits disagree with entry count");

  a_dump_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (count_q != '0) && (idx_q < count_q))
    else $error("dump running past list end");

  a_append_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (mode_i == okl_pkg::ModeAppend) && (count_q != Depth))
      |=> (count_q == $past(count_q) + CountW'(1)))
    else $error("append did not grow list");

  a_error_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != okl_pkg::StatusOk)) |-> out_last_q)
    else $error("error word not marked last");

endmodule

// ----- rtl/okl_cell.sv -----
module okl_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  okl_pkg::cell_ctrl_t              ctrl_i,
  input  logic signed [okl_pkg::KeyW-1:0]  key_i,
  input  logic signed [okl_pkg::KeyW-1:0]  head_key_i,
  input  logic                             prev_valid_i,
  input  logic signed [okl_pkg::KeyW-1:0]  nbr_entry_i,
  input  logic                             nbr_valid_i,
  input  logic                             hit_i,
  output logic                             hit_o,
  output logic signed [okl_pkg::KeyW-1:0]  entry_o,
  output logic                             valid_o
);

  logic signed [okl_pkg::KeyW-1:0] entry_q, entry_d;
  logic                            valid_q, valid_d;
  logic                            match;

  assign match   = valid_q && (entry_q == key_i);
  assign hit_o   = hit_i | match;
  assign entry_o = entry_q;
  assign valid_o = valid_q;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.append && !valid_q && prev_valid_i) begin
      entry_d = key_i;
      valid_d = 1'b1;
    end else if (ctrl_i.remove && hit_o) begin
      entry_d = nbr_entry_i;
      valid_d = nbr_valid_i;
    end else if (ctrl_i.rotate && valid_q) begin
      entry_d = nbr_valid_i ? nbr_entry_i : head_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- tb/okl_result_checker.sv -----
`timescale 1ns / 100ps

module okl_result_checker #(
  parameter int unsigned LIST_DEPTH = okl_pkg::ListDepthDefault,
  localparam int unsigned CountW = $clog2(LIST_DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [okl_pkg::ModeW-1:0]       mode_i,
  input  logic signed [okl_pkg::KeyW-1:0] key_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic signed [okl_pkg::KeyW-1:0] entry_key_i,
  input  logic [okl_pkg::StatusW-1:0]     status_i,
  input  logic [CountW-1:0]               entry_count_i,
  input  logic                            last_i,
  output int                              mismatch_count_o,
  output int                              words_pending_o
);

  import okl_pkg::*;

  typedef struct packed {
    logic signed [KeyW-1:0] entry_key;
    logic [StatusW-1:0]     status;
    logic [CountW-1:0]      entry_count;
    logic                   last;
  } list_word_t;

  logic signed [KeyW-1:0] list_keys[$];
  list_word_t             expected_words[$];
  list_word_t             exp_word;

  function automatic void push_word(logic signed [KeyW-1:0] entry_key,
                                    logic [StatusW-1:0] status, logic last);
    list_word_t w;
    w.entry_key   = entry_key;
    w.status      = status;
    w.entry_count = CountW'(list_keys.size());
    w.last        = last;
    expected_words.push_back(w);
  endfunction

  // mode high bit selects a dump, so the spare mode dumps too
  function automatic void apply_list_op(logic [ModeW-1:0] mode, logic signed [KeyW-1:0] key);
    int hit;
    hit = -1;
    if (mode[1]) begin
      if (list_keys.size() == 0) begin
        push_word('0, StatusEmpty, 1'b1);
      end else begin
        foreach (list_keys[i]) begin
          push_word(list_keys[i], StatusOk, i == list_keys.size() - 1);
        end
      end
    end else if (mode == ModeAppend) begin
      if (list_keys.size() >= LIST_DEPTH) begin
        push_word('0, StatusFull, 1'b1);
      end else begin
        list_keys.push_back(key);
        push_word('0, StatusOk, 1'b1);
      end
    end else begin
      foreach (list_keys[i]) begin
        if (hit < 0 && list_keys[i] == key) hit = i;
      end
      if (hit < 0) begin
        push_word('0, StatusNotFound, 1'b1);
      end else begin
        list_keys.delete(hit);
        push_word('0, StatusOk, 1'b1);
      end
    end
  endfunction

  initial begin
    mismatch_count_o = 0;
    words_pending_o  = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: entry_key %0d status %0d entry_count %0d last %0d",
                 entry_key_i, status_i, entry_count_i, last_i);
          mismatch_count_o++;
        end else begin
          exp_word = expected_words.pop_front();
          if (entry_key_i !== exp_word.entry_key) begin
            $error("entry_key expected %0d actual %0d", exp_word.entry_key, entry_key_i);
            mismatch_count_o++;
          end
          if (status_i !== exp_word.status) begin
            $error("status expected %0d actual %0d", exp_word.status, status_i);
            mismatch_count_o++;
          end
          if (entry_count_i !== exp_word.entry_count) begin
            $error("entry_count expected %0d actual %0d", exp_word.entry_count,
                   entry_count_i);
            mismatch_count_o++;
          end
          if (last_i !== exp_word.last) begin
            $error("last expected %0d actual %0d", exp_word.last, last_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_list_op(mode_i, key_i);
      words_pending_o = expected_words.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  import okl_pkg::*;

  localparam int unsigned ListDepth = ListDepthDefault;
  localparam int unsigned CountW = $clog2(ListDepth + 1);
  localparam logic [ModeW-1:0] ModeDump = 2'd2;
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;
  localparam int RandomWords = 120;
  localparam int HoldCycles = 80;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [ModeW-1:0]       mode;
  logic signed [KeyW-1:0] key;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [KeyW-1:0] entry_key;
  logic [StatusW-1:0]     status;
  logic [CountW-1:0]      entry_count;
  logic                   last;
  int                     mismatch_count;
  int                     words_pending;

  bit no_idle;
  bit hold_req;

  logic signed [KeyW-1:0] key_pool[10] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 42, -42, 1000, 32'sh5555_5555, 32'shaaaa_aaaa
  };

  ordered_key_list_unit #(
    .LIST_DEPTH(ListDepth)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mode_i       (mode),
    .key_i        (key),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .entry_key_o  (entry_key),
    .status_o     (status),
    .entry_count_o(entry_count),
    .last_o       (last)
  );

  okl_result_checker #(
    .LIST_DEPTH(ListDepth)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .mode_i          (mode),
    .key_i           (key),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .entry_key_i     (entry_key),
    .status_i        (status),
    .entry_count_i   (entry_count),
    .last_i          (last),
    .mismatch_count_o(mismatch_count),
    .words_pending_o (words_pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [KeyW-1:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 9)];
    return $urandom();
  endfunction

  task automatic send_word(input logic [ModeW-1:0] m, input logic signed [KeyW-1:0] k);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    key      <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int c = 0; c < HoldCycles; c++) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = gap_len();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    logic [ModeW-1:0] m;
    in_valid <= 1'b0;
    mode     <= ModeAppend;
    key      <= '0;
    no_idle  = 1'b0;
    hold_req = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // empty list cases
    send_word(ModeDump, 32'sd7);
    send_word(ModeRemove, 32'sd0);
    // extremes, duplicate key, first-match remove
    send_word(ModeAppend, 32'sh8000_0000);
    send_word(ModeAppend, 32'sh7fff_ffff);
    send_word(ModeAppend, -32'sd1);
    send_word(ModeAppend, 32'sd0);
    send_word(ModeAppend, -32'sd1);
    send_word(ModeRemove, -32'sd1);
    send_word(ModeRemove, 32'sd7);
    send_word(ModeSpare, 32'sh1234_5678);
    // fill to the top, then overflow
    repeat (12) send_word(ModeAppend, $urandom());
    send_word(ModeAppend, 32'sd99);
    send_word(ModeDump, '0);
    send_word(ModeRemove, 32'sh8000_0000);

    for (int n = 0; n < RandomWords; n++) begin
      if (n % 24 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == 48) begin
        no_idle  = 1'b1;
        hold_req = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 40) m = ModeAppend;
      else if (r < 82) m = ModeRemove;
      else if (r < 95) m = ModeDump;
      else m = ModeSpare;
      send_word(m, pick_key());
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/okl_pkg.sv
rtl/okl_cell.sv
rtl/ordered_key_list_unit.sv
tb/okl_result_checker.sv
tb/testbench.sv
